[rtl/core/gobd_pkg.sv]
// ============================================================================
// gobd_pkg
// Shared widths, item codes and the request record for the outline dilation
// block.
// ============================================================================
package gobd_pkg;

    localparam int MAX_WIDTH = 256;

    localparam int CFG_W   = 9;
    localparam int PIX_W   = 8;
    localparam int ADDR_W  = $clog2(MAX_WIDTH);
    localparam int W_W     = $clog2(MAX_WIDTH + 1);
    localparam int COL_W   = $clog2(MAX_WIDTH + 3);
    localparam int DRAIN_W = $clog2(2 * MAX_WIDTH + 5);
    localparam int CSUM_W  = 10;
    localparam int BOX_W   = 12;
    localparam int LINE_W  = 2 * PIX_W;

    localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(16);
    localparam logic [PIX_W-1:0] ALPHA_MAX   = 8'hFF;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic              pixel;
        logic [PIX_W-1:0]  value;
        logic [ADDR_W-1:0] addr;
        logic              use_a;
        logic              use_b;
        logic              ge1;
        logic              ge2;
        logic              three;
        logic              row_end;
        logic              frame_end;
    } gobd_req_t;

endpackage

[rtl/core/gobd_line_ram.sv]
// ============================================================================
// gobd_line_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module gobd_line_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/gobd_ctrl.sv]
// ============================================================================
// gobd_ctrl
// Tracks width register, source column, completed rows and drain position;
// issues one line-buffer request per accepted item, none for mid-drain pixels.
// ============================================================================
module gobd_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [gobd_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic                               accept,
    input  logic                               in_op,
    input  logic [gobd_pkg::PIX_W-1:0]         in_value,
    output logic                               req_load,
    output gobd_pkg::gobd_req_t                req
);

    logic [gobd_pkg::CFG_W-1:0]   width_reg;
    logic [gobd_pkg::ADDR_W-1:0]  col_idx_reg, col_idx_next;
    logic [1:0]                   rows_reg, rows_next;
    logic [gobd_pkg::DRAIN_W-1:0] drain_reg, drain_next;

    logic [gobd_pkg::W_W-1:0]     w_eff;
    logic [gobd_pkg::COL_W-1:0]   w2;
    logic [gobd_pkg::COL_W-1:0]   col;
    logic [gobd_pkg::DRAIN_W-1:0] drain_off;
    logic                         pix_last;
    logic                         in_row0;
    logic                         in_img;
    logic                         end_row;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = gobd_pkg::W_W'(1);
        end else if (32'(width_reg) > gobd_pkg::MAX_WIDTH) begin
            w_eff = gobd_pkg::W_W'(gobd_pkg::MAX_WIDTH);
        end else begin
            w_eff = gobd_pkg::W_W'(width_reg);
        end

        pix_last = (gobd_pkg::COL_W'(col_idx_reg) + gobd_pkg::COL_W'(1))
                   >= gobd_pkg::COL_W'(w_eff);
        w2        = gobd_pkg::COL_W'(w_eff) + gobd_pkg::COL_W'(2);
        in_row0   = drain_reg < gobd_pkg::DRAIN_W'(w2);
        drain_off = drain_reg - gobd_pkg::DRAIN_W'(w2);

        if (in_row0) begin
            col = drain_reg[gobd_pkg::COL_W-1:0];
        end else if (drain_off > gobd_pkg::DRAIN_W'(w2 - gobd_pkg::COL_W'(1))) begin
            col = w2 - gobd_pkg::COL_W'(1);
        end else begin
            col = drain_off[gobd_pkg::COL_W-1:0];
        end
        in_img  = col < gobd_pkg::COL_W'(w_eff);
        end_row = col == (w2 - gobd_pkg::COL_W'(1));

        req = '0;
        if (in_op == gobd_pkg::OP_PIXEL) begin
            req.pixel = 1'b1;
            req.value = in_value;
            req.addr  = col_idx_reg;
            req.use_a = rows_reg >= 2'd1;
            req.use_b = rows_reg >= 2'd2;
            req.ge1   = col_idx_reg >= gobd_pkg::ADDR_W'(1);
            req.ge2   = col_idx_reg >= gobd_pkg::ADDR_W'(2);
            req.three = pix_last;
        end else begin
            req.addr      = col[gobd_pkg::ADDR_W-1:0];
            req.use_a     = (rows_reg >= 2'd1) && in_img;
            req.use_b     = in_row0 && (rows_reg >= 2'd2) && in_img;
            req.ge1       = col >= gobd_pkg::COL_W'(1);
            req.ge2       = col >= gobd_pkg::COL_W'(2);
            req.row_end   = end_row;
            req.frame_end = !in_row0 && end_row;
        end

        req_load     = 1'b0;
        col_idx_next = col_idx_reg;
        rows_next    = rows_reg;
        drain_next   = drain_reg;
        if (accept) begin
            if (in_op == gobd_pkg::OP_PIXEL) begin
                if (drain_reg == '0) begin
                    req_load = 1'b1;
                    if (pix_last) begin
                        col_idx_next = '0;
                        if (rows_reg < 2'd2) begin
                            rows_next = rows_reg + 2'd1;
                        end
                    end else begin
                        col_idx_next = col_idx_reg + gobd_pkg::ADDR_W'(1);
                    end
                end
            end else begin
                req_load = 1'b1;
                if (!in_row0 && end_row) begin
                    col_idx_next = '0;
                    rows_next    = '0;
                    drain_next   = '0;
                end else begin
                    drain_next = drain_reg + gobd_pkg::DRAIN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= gobd_pkg::WIDTH_RESET;
            col_idx_reg <= '0;
            rows_reg    <= '0;
            drain_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                width_reg <= cfg_wr_data;
            end
            col_idx_reg <= col_idx_next;
            rows_reg    <= rows_next;
            drain_reg   <= drain_next;
        end
    end

endmodule

[rtl/core/gobd_sum.sv]
// ============================================================================
// gobd_sum
// Result stage: column sum from line-buffer data, 3-wide box sum with
// saturation, row-end expansion to three results, line write-back and the
// output register.
// ============================================================================
module gobd_sum (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              load,
    input  gobd_pkg::gobd_req_t               req_in,
    input  logic [gobd_pkg::LINE_W-1:0]       ram_q,
    output logic                              free,
    output logic                              wr_en,
    output logic [gobd_pkg::ADDR_W-1:0]       wr_addr,
    output logic [gobd_pkg::LINE_W-1:0]       wr_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [gobd_pkg::PIX_W-1:0]        m_tdata,
    output logic                              m_tlast,
    output logic                              m_tuser
);

    logic                             s1_valid_reg;
    gobd_pkg::gobd_req_t              s1_req_reg;
    logic [1:0]                       step_reg, step_next;
    logic                             byp_valid_reg;
    logic [gobd_pkg::LINE_W-1:0]      byp_data_reg;
    logic [gobd_pkg::CSUM_W-1:0]      prev_reg, prev_next;
    logic [gobd_pkg::CSUM_W-1:0]      prev2_reg, prev2_next;
    logic                             out_valid_reg;
    logic [gobd_pkg::PIX_W-1:0]       alpha_reg;
    logic                             row_end_reg;
    logic                             frame_end_reg;

    logic [gobd_pkg::LINE_W-1:0]      line_q;
    logic [gobd_pkg::PIX_W-1:0]       above;
    logic [gobd_pkg::PIX_W-1:0]       two_above;
    logic [gobd_pkg::CSUM_W-1:0]      colsum;
    logic [gobd_pkg::CSUM_W-1:0]      cs;
    logic [gobd_pkg::BOX_W-1:0]       box;
    logic [gobd_pkg::PIX_W-1:0]       alpha_next;
    logic                             g1, g2;
    logic                             row_end_next, frame_end_next;
    logic                             out_ready, emit, last_step, finish;

    always_comb begin
        line_q    = byp_valid_reg ? byp_data_reg : ram_q;
        above     = line_q[gobd_pkg::LINE_W-1:gobd_pkg::PIX_W];
        two_above = line_q[gobd_pkg::PIX_W-1:0];

        colsum = (s1_req_reg.pixel ? gobd_pkg::CSUM_W'(s1_req_reg.value) : '0)
               + (s1_req_reg.use_a ? gobd_pkg::CSUM_W'(above) : '0)
               + (s1_req_reg.use_b ? gobd_pkg::CSUM_W'(two_above) : '0);

        cs = (step_reg == 2'd0) ? colsum : '0;
        g1 = (step_reg == 2'd0) ? s1_req_reg.ge1 : 1'b1;
        unique case (step_reg)
            2'd0:    g2 = s1_req_reg.ge2;
            2'd1:    g2 = s1_req_reg.ge1;
            default: g2 = 1'b1;
        endcase

        box = gobd_pkg::BOX_W'(cs)
            + (g1 ? gobd_pkg::BOX_W'(prev_reg) : '0)
            + (g2 ? gobd_pkg::BOX_W'(prev2_reg) : '0);
        alpha_next = (box > gobd_pkg::BOX_W'(gobd_pkg::ALPHA_MAX))
                   ? gobd_pkg::ALPHA_MAX : box[gobd_pkg::PIX_W-1:0];

        row_end_next   = (step_reg == 2'd0) ? s1_req_reg.row_end : (step_reg == 2'd2);
        frame_end_next = (step_reg == 2'd0) ? s1_req_reg.frame_end : 1'b0;

        out_ready = !out_valid_reg || m_tready;
        emit      = s1_valid_reg && out_ready;
        last_step = !s1_req_reg.three || (step_reg == 2'd2);
        finish    = emit && last_step;
        free      = !s1_valid_reg || finish;

        step_next = finish ? 2'd0 : (emit ? step_reg + 2'd1 : step_reg);

        prev_next  = prev_reg;
        prev2_next = prev2_reg;
        if (emit) begin
            if (frame_end_next) begin
                prev_next  = '0;
                prev2_next = '0;
            end else begin
                prev_next  = cs;
                prev2_next = prev_reg;
            end
        end

        wr_en   = finish && s1_req_reg.pixel;
        wr_addr = s1_req_reg.addr;
        wr_data = {s1_req_reg.value, above};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            step_reg      <= '0;
            byp_valid_reg <= 1'b0;
            prev_reg      <= '0;
            prev2_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            prev_reg  <= prev_next;
            prev2_reg <= prev2_next;
            if (load) begin
                s1_valid_reg  <= 1'b1;
                byp_valid_reg <= wr_en && (wr_addr == req_in.addr);
            end else if (finish) begin
                s1_valid_reg <= 1'b0;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            s1_req_reg   <= req_in;
            byp_data_reg <= wr_data;
        end
        if (emit) begin
            alpha_reg     <= alpha_next;
            row_end_reg   <= row_end_next;
            frame_end_reg <= frame_end_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = alpha_reg;
    assign m_tlast  = row_end_reg;
    assign m_tuser  = frame_end_reg;

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> free)
        else $error("request loaded while result stage busy");

    a_write_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (s1_valid_reg && out_ready))
        else $error("line write without a finishing pixel");

    a_single_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_req_reg.three) |-> (step_reg == 2'd0))
        else $error("step counter moved on a single-result item");

    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && frame_end_next) |=> (prev_reg == '0 && prev2_reg == '0))
        else $error("column history not cleared at frame end");

endmodule

[rtl/core/glyph_outline_box_dilate.sv]
// ============================================================================
// glyph_outline_box_dilate
// Saturating 3x3 box-sum dilation of a raster-order glyph coverage image.
// ----------------------------------------------------------------------------
// Input requests on s_*: tuser 0 carries a source pixel in tdata, tuser 1 is
// a drain tick. Results on m_*: tdata is the outline alpha, tlast marks the
// end of an output row, tuser marks the end of the output frame.
// cfg_wr_en/cfg_wr_data load the source width; write it only while idle.
// Each source pixel gives one result, the last pixel of a row three; pixels sent
// during a drain are dropped. After the last row, 2*(W+2) drain ticks emit
// the two trailing rows, and the final one restarts the frame.
// A request passes the result stage register, then the output register.
// Throughput: one request per cycle while m_tready is high; a row-end pixel
// holds the result stage for its three results, as the single output register
// passes one result per cycle. The two previous rows sit in one 256 x 16 line
// RAM with a registered read; a same-address write-back is forwarded to the
// next read. Reset: width returns to 16, frame position clears, no results
// pending. Line RAM contents are not cleared. When m_tready is low the output
// register holds, the result stage stalls and s_tready drops once it is full.
// ============================================================================
module glyph_outline_box_dilate (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [gobd_pkg::CFG_W-1:0]  cfg_wr_data,   // image_width
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [gobd_pkg::PIX_W-1:0]  s_tdata,       // [7:0] pixel_value
    input  logic                        s_tuser,       // [0] op
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [gobd_pkg::PIX_W-1:0]  m_tdata,       // [7:0] outline_alpha
    output logic                        m_tlast,
    output logic                        m_tuser        // [0] frame_end
);

    logic                             accept;
    logic                             req_load;
    gobd_pkg::gobd_req_t              req;
    logic [gobd_pkg::LINE_W-1:0]      ram_q;
    logic                             wr_en;
    logic [gobd_pkg::ADDR_W-1:0]      wr_addr;
    logic [gobd_pkg::LINE_W-1:0]      wr_data;
    logic                             free;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = free && aresetn;

    gobd_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .in_op       (s_tuser),
        .in_value    (s_tdata),
        .req_load    (req_load),
        .req         (req)
    );

    gobd_line_ram #(
        .DATA_W (gobd_pkg::LINE_W),
        .DEPTH  (gobd_pkg::MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (req_load),
        .raddr (req.addr),
        .rdata (ram_q)
    );

    gobd_sum u_sum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (req_load),
        .req_in   (req),
        .ram_q    (ram_q),
        .free     (free),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Stream test of the glyph outline dilation block.
// ----------------------------------------------------------------------------
// Pixel and drain requests go in on s_*. A predictor mirrors the line
// buffers, the column sums and the frame position, and queues the expected
// outline pixels. Each m_* result is checked against the oldest one. Directed
// tests cover the corner cases, then random frames follow. The sender bursts
// and the receiver stalls at random.
// ============================================================================
module tb_top;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_REQUESTS = 120;

    typedef struct packed {
        logic [gobd_pkg::PIX_W-1:0] alpha;
        logic                       row_end;
        logic                       frame_end;
    } outline_px_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [gobd_pkg::CFG_W-1:0] cfg_wr_data;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [gobd_pkg::PIX_W-1:0] s_tdata;      // [7:0] pixel_value
    logic                       s_tuser;      // [0] op
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [gobd_pkg::PIX_W-1:0] m_tdata;      // [7:0] outline_alpha
    logic                       m_tlast;
    logic                       m_tuser;      // [0] frame_end

    glyph_outline_box_dilate dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    // predictor state
    logic [gobd_pkg::CFG_W-1:0] width_reg;
    logic [gobd_pkg::PIX_W-1:0] row_above [gobd_pkg::MAX_WIDTH];
    logic [gobd_pkg::PIX_W-1:0] row_two_above [gobd_pkg::MAX_WIDTH];
    int unsigned      colsum_last;
    int unsigned      colsum_last2;
    int unsigned      next_col;
    int unsigned      rows_done;
    int unsigned      drain_ticks;
    outline_px_t      pending_px [$];

    int unsigned      error_count = 0;
    int unsigned      quiet_cycles = 0;
    int unsigned      burst_left;
    int unsigned      stall_left = 0;
    bit               gaps_on;
    bit               stalls_on;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        error_count++;
    endtask

    function automatic int unsigned active_width();
        if (width_reg == 0) return 1;
        if (width_reg > gobd_pkg::MAX_WIDTH) return gobd_pkg::MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic void push_box(input int unsigned colsum, input int unsigned col,
                                     input logic row_end, input logic frame_end);
        int unsigned total;
        outline_px_t px;
        total = colsum;
        if (col >= 1) total += colsum_last;
        if (col >= 2) total += colsum_last2;
        colsum_last2 = colsum_last;
        colsum_last = colsum;
        px.alpha = (total > gobd_pkg::ALPHA_MAX) ? gobd_pkg::ALPHA_MAX
                                                 : total[gobd_pkg::PIX_W-1:0];
        px.row_end = row_end;
        px.frame_end = frame_end;
        pending_px.push_back(px);
    endfunction

    function automatic void restart_frame();
        colsum_last = 0;
        colsum_last2 = 0;
        next_col = 0;
        rows_done = 0;
        drain_ticks = 0;
    endfunction

    function automatic void predict_request(input logic op,
                                            input logic [gobd_pkg::PIX_W-1:0] pix);
        int unsigned w;
        int unsigned w2;
        int unsigned x;
        int unsigned a;
        int unsigned b;
        int unsigned col;
        int unsigned colsum;
        bit          second_row;
        logic        last_col;
        w = active_width();
        if (op == gobd_pkg::OP_PIXEL) begin
            if (drain_ticks != 0) return;
            x = next_col;
            a = 0;
            b = 0;
            if (x < gobd_pkg::MAX_WIDTH) begin
                if (rows_done >= 1) a = row_above[x];
                if (rows_done >= 2) b = row_two_above[x];
                row_two_above[x] = row_above[x];
                row_above[x] = pix;
            end
            push_box(pix + a + b, x, 1'b0, 1'b0);
            if (x + 1 < w) begin
                next_col = x + 1;
            end else begin
                push_box(0, x + 1, 1'b0, 1'b0);
                push_box(0, x + 2, 1'b1, 1'b0);
                next_col = 0;
                if (rows_done < 2) rows_done++;
            end
        end else begin
            w2 = w + 2;
            second_row = (drain_ticks >= w2);
            col = second_row ? drain_ticks - w2 : drain_ticks;
            if (col > w2 - 1) col = w2 - 1;
            colsum = 0;
            if (col < w && col < gobd_pkg::MAX_WIDTH) begin
                if (rows_done >= 1) colsum += row_above[col];
                if (!second_row && rows_done >= 2) colsum += row_two_above[col];
            end
            last_col = (col == w2 - 1);
            push_box(colsum, col, last_col, second_row & last_col);
            if (second_row && last_col) restart_frame();
            else drain_ticks++;
        end
    endfunction

    task automatic send_request(input logic op, input logic [gobd_pkg::PIX_W-1:0] pix);
        if (burst_left == 0) begin
            if (gaps_on) begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = pix;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_request(op, pix);
        burst_left--;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_pixel(input logic [gobd_pkg::PIX_W-1:0] pix);
        send_request(gobd_pkg::OP_PIXEL, pix);
    endtask

    task automatic send_drain();
        send_request(gobd_pkg::OP_DRAIN, gobd_pkg::PIX_W'($urandom));
    endtask

    task automatic wait_idle();
        while (pending_px.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_width(input logic [gobd_pkg::CFG_W-1:0] value);
        wait_idle();
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        width_reg = value;
    endtask

    task automatic drain_frame();
        do begin
            if (drain_ticks != 0 && $urandom_range(0, 7) == 0)
                send_pixel(gobd_pkg::PIX_W'($urandom));
            send_drain();
        end while (drain_ticks != 0);
    endtask

    function automatic logic [gobd_pkg::PIX_W-1:0] random_coverage();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return gobd_pkg::ALPHA_MAX;
            default: return gobd_pkg::PIX_W'($urandom);
        endcase
    endfunction

    task automatic test_empty_frame();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        write_width('0);
        drain_frame();
    endtask

    task automatic test_saturation();
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        write_width(3);
        send_pixel(8'hFF); send_pixel(8'h00); send_pixel(8'h01);
        send_pixel(8'h00); send_pixel(8'h80); send_pixel(8'hFF);
        send_pixel(8'hFF); send_pixel(8'hFF); send_pixel(8'h7F);
        send_drain();
        send_pixel(8'hAA);
        drain_frame();
    endtask

    task automatic test_drain_mid_row();
        gaps_on = 1'b0;
        stalls_on = 1'b1;
        write_width(4);
        repeat (4) send_pixel(random_coverage());
        send_pixel(8'h55);
        send_pixel(8'hFE);
        drain_frame();
    endtask

    task automatic test_shrink_mid_row();
        gaps_on = 1'b1;
        stalls_on = 1'b0;
        write_width(8);
        repeat (8) send_pixel(random_coverage());
        repeat (5) send_pixel(random_coverage());
        write_width(3);
        send_pixel(8'hC3);
        repeat (3) send_pixel(random_coverage());
        drain_frame();
    endtask

    task automatic test_widest_row();
        gaps_on = 1'b0;
        stalls_on = 1'b1;
        write_width('1);
        repeat (gobd_pkg::MAX_WIDTH) send_pixel(random_coverage());
        repeat (5) send_drain();
        write_width(1);
        drain_frame();
    endtask

    task automatic test_random_frames();
        int unsigned sent;
        int unsigned w;
        int unsigned rows;
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            gaps_on = $urandom_range(0, 2) != 0;
            stalls_on = $urandom_range(0, 2) != 0;
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 9))
                    0: write_width(gobd_pkg::CFG_W'($urandom_range(0, 2)));
                    1: write_width(gobd_pkg::CFG_W'($urandom_range(13, 24)));
                    default: write_width(gobd_pkg::CFG_W'($urandom_range(1, 8)));
                endcase
            end
            w = active_width();
            rows = $urandom_range(0, 4);
            repeat (rows * w) send_pixel(random_coverage());
            sent += rows * w;
            if (w > 1 && $urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, w - 1)) begin
                    send_pixel(random_coverage());
                    sent++;
                end
            end
            drain_frame();
            sent += 2 * (w + 2);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = gobd_pkg::OP_PIXEL;
        width_reg = gobd_pkg::WIDTH_RESET;
        for (int i = 0; i < gobd_pkg::MAX_WIDTH; i++) begin
            row_above[i] = '0;
            row_two_above[i] = '0;
        end
        restart_frame();
        burst_left = 0;
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_frame();
        test_saturation();
        test_drain_mid_row();
        test_shrink_mid_row();
        test_widest_row();
        test_random_frames();

        wait_idle();
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else if (stalls_on && $urandom_range(0, 9) < 3) begin
            m_tready = 1'b0;
            stall_left = $urandom_range(0, 7);
        end else begin
            m_tready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        outline_px_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_px.size() == 0) begin
                report_mismatch("unrequested result, alpha", m_tdata, 0);
            end else begin
                want = pending_px.pop_front();
                if (m_tdata !== want.alpha) report_mismatch("outline_alpha", m_tdata, want.alpha);
                if (m_tlast !== want.row_end) report_mismatch("row_end", m_tlast, want.row_end);
                if (m_tuser !== want.frame_end)
                    report_mismatch("frame_end", m_tuser, want.frame_end);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule
